// ----- rtl/bitp_pkg.sv -----
// Shared types and codes for the boolean infix-to-postfix converter.
// No dependencies; every other file in rtl/ imports this package.
package bitp_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int KIND_W = 3;
  localparam int ID_W   = 24;
  localparam int ERR_W  = 2;

  // Input token kind codes
  localparam logic [KIND_W-1:0] TK_OPERAND = 3'd0;
  localparam logic [KIND_W-1:0] TK_LPAREN  = 3'd1;
  localparam logic [KIND_W-1:0] TK_RPAREN  = 3'd2;
  localparam logic [KIND_W-1:0] TK_NOT     = 3'd3;
  localparam logic [KIND_W-1:0] TK_AND     = 3'd4;
  localparam logic [KIND_W-1:0] TK_OR      = 3'd5;

  // Output kind codes (operator kinds equal the stack code)
  localparam logic [KIND_W-1:0] OUT_OPERAND = 3'd0;
  localparam logic [KIND_W-1:0] OUT_END     = 3'd4;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RPAREN   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LPAREN   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd3;

  // Operator stack entry codes
  typedef enum logic [1:0] {
    OP_LP  = 2'd0,
    OP_NOT = 2'd1,
    OP_AND = 2'd2,
    OP_OR  = 2'd3
  } op_t;

  // Token class after front-end decode
  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_NOT,
    CLS_AND,
    CLS_OR,
    CLS_NONE
  } tok_cls_t;

  // Classified token as it travels through the queue
  typedef struct packed {
    tok_cls_t               cls;
    op_t                    op;
    logic                   starts_term;
    logic signed [ID_W-1:0] id;
    logic                   last;
  } tok_t;

endpackage

// ----- rtl/bitp_queue.sv -----
// Two-entry token queue between the decode front end and the stack engine.
// Depends on bitp_pkg (tok_t, QUEUE_DEPTH).
module bitp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bitp_pkg::tok_t  push_tok,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output bitp_pkg::tok_t  head
);
  import bitp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tok_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Store incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/bitp_front.sv -----
// Front end: takes input beats while the queue has room and decodes the kind.
// Depends on bitp_pkg (token codes, tok_t).
module bitp_front (
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bitp_pkg::KIND_W-1:0]        in_token_kind,
  input  logic signed [bitp_pkg::ID_W-1:0]   in_operand_id,
  input  logic                               in_last_token,
  input  logic                               q_full,
  output logic                               q_push,
  output bitp_pkg::tok_t                     q_tok
);
  import bitp_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Decode kind into class, stack code and term-start flag
  always_comb begin
    q_tok.id          = in_operand_id;
    q_tok.last        = in_last_token;
    q_tok.op          = OP_LP;
    q_tok.starts_term = 1'b0;
    unique case (in_token_kind)
      TK_OPERAND: begin
        q_tok.cls         = CLS_OPERAND;
        q_tok.starts_term = 1'b1;
      end
      TK_LPAREN: begin
        q_tok.cls         = CLS_LPAREN;
        q_tok.starts_term = 1'b1;
      end
      TK_RPAREN: begin
        q_tok.cls = CLS_RPAREN;
      end
      TK_NOT: begin
        q_tok.cls         = CLS_NOT;
        q_tok.op          = OP_NOT;
        q_tok.starts_term = 1'b1;
      end
      TK_AND: begin
        q_tok.cls = CLS_AND;
        q_tok.op  = OP_AND;
      end
      TK_OR: begin
        q_tok.cls = CLS_OR;
        q_tok.op  = OP_OR;
      end
      default: begin
        q_tok.cls = CLS_NONE;
      end
    endcase
  end

endmodule

// ----- rtl/bitp_back.sv -----
// Back end: operator stack sequencer that emits postfix items, finishing each token before it takes the next.
// Depends on bitp_pkg (tok_t, op_t, output and error codes).
module bitp_back #(
  parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               impl_and_en,
  input  logic                               q_valid,
  input  bitp_pkg::tok_t                     q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bitp_pkg::KIND_W-1:0]        out_kind,
  output logic signed [bitp_pkg::ID_W-1:0]   out_id,
  output logic                               out_last,
  output logic [bitp_pkg::ERR_W-1:0]         out_error_code
);
  import bitp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_IMPL  = 5'b00010,
    ST_MAIN  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_END   = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  tok_t                   tok_r, tok_nxt;
  op_t                    stk_r [STACK_DEPTH];
  logic [CW-1:0]          cnt_r;
  logic                   prev_r, prev_nxt;
  logic                   err_lat_r, err_lat_nxt;
  logic [ERR_W-1:0]       err_r, err_nxt;
  logic                   emitted_r, emitted_nxt;

  logic                   ovalid_r;
  logic [KIND_W-1:0]      okind_r;
  logic signed [ID_W-1:0] oid_r;
  logic                   olast_r;
  logic [ERR_W-1:0]       oerr_r;

  logic                   can_emit;
  logic                   do_emit;
  logic [KIND_W-1:0]      e_kind;
  logic signed [ID_W-1:0] e_id;
  logic                   e_last;
  logic [ERR_W-1:0]       e_err;
  logic                   do_push;
  op_t                    push_code;
  logic                   do_pop;
  logic                   do_clear;

  op_t                    top;
  op_t                    below;
  logic                   stk_empty;
  logic                   stk_full;

  assign top       = stk_r[0];
  assign below     = stk_r[1];
  assign stk_empty = (cnt_r == '0);
  assign stk_full  = (cnt_r == CW'(STACK_DEPTH));
  assign can_emit  = !ovalid_r || out_ready;

  // True when the top entry binds at least as tight as operator c
  function automatic logic pops_over(input op_t t, input logic nonempty, input op_t c);
    pops_over = nonempty && (t != OP_LP) && (t <= c);
  endfunction

  // Sequence one token: implicit AND, the token itself, then the end flush or an error marker
  always_comb begin
    state_nxt   = state_r;
    tok_nxt     = tok_r;
    prev_nxt    = prev_r;
    err_lat_nxt = err_lat_r;
    err_nxt     = err_r;
    emitted_nxt = emitted_r;
    q_pop       = 1'b0;
    do_emit     = 1'b0;
    e_kind      = OUT_END;
    e_id        = '0;
    e_last      = 1'b0;
    e_err       = ERR_NONE;
    do_push     = 1'b0;
    push_code   = OP_LP;
    do_pop      = 1'b0;
    do_clear    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (err_lat_r) begin
            // Drop tokens until the end of the broken expression
            if (q_head.last) begin
              do_clear    = 1'b1;
              err_lat_nxt = 1'b0;
            end
          end else begin
            tok_nxt     = q_head;
            emitted_nxt = 1'b0;
            err_nxt     = ERR_NONE;
            if (impl_and_en && prev_r && q_head.starts_term) begin
              state_nxt = ST_IMPL;
            end else begin
              state_nxt = ST_MAIN;
            end
          end
        end
      end

      ST_IMPL: begin
        if (pops_over(top, !stk_empty, OP_AND)) begin
          if (can_emit) begin
            do_emit = 1'b1;
            e_kind  = {1'b0, top};
            do_pop  = 1'b1;
          end
        end else if (stk_full) begin
          err_nxt   = ERR_OVERFLOW;
          state_nxt = ST_END;
        end else begin
          do_push   = 1'b1;
          push_code = OP_AND;
          state_nxt = ST_MAIN;
        end
      end

      ST_MAIN: begin
        case (tok_r.cls)
          CLS_OPERAND: begin
            if (can_emit) begin
              do_emit   = 1'b1;
              e_kind    = OUT_OPERAND;
              e_id      = tok_r.id;
              e_last    = tok_r.last && stk_empty;
              prev_nxt  = 1'b1;
              state_nxt = tok_r.last ? ST_FLUSH : ST_IDLE;
            end
          end
          CLS_LPAREN, CLS_NOT: begin
            if (stk_full) begin
              err_nxt   = ERR_OVERFLOW;
              state_nxt = ST_END;
            end else begin
              do_push   = 1'b1;
              push_code = tok_r.op;
              prev_nxt  = 1'b0;
              state_nxt = tok_r.last ? ST_FLUSH : ST_IDLE;
            end
          end
          CLS_AND, CLS_OR: begin
            if (pops_over(top, !stk_empty, tok_r.op)) begin
              if (can_emit) begin
                do_emit = 1'b1;
                e_kind  = {1'b0, top};
                do_pop  = 1'b1;
              end
            end else if (stk_full) begin
              err_nxt   = ERR_OVERFLOW;
              state_nxt = ST_END;
            end else begin
              do_push   = 1'b1;
              push_code = tok_r.op;
              prev_nxt  = 1'b0;
              state_nxt = tok_r.last ? ST_FLUSH : ST_IDLE;
            end
          end
          CLS_RPAREN: begin
            if (!stk_empty && top != OP_LP) begin
              if (can_emit) begin
                // Final item if only the matching paren remains below
                do_emit = 1'b1;
                e_kind  = {1'b0, top};
                e_last  = tok_r.last && (cnt_r == CW'(2)) && (below == OP_LP);
                do_pop  = 1'b1;
              end
            end else if (stk_empty) begin
              err_nxt   = ERR_RPAREN;
              state_nxt = ST_END;
            end else begin
              do_pop    = 1'b1;
              prev_nxt  = 1'b1;
              state_nxt = tok_r.last ? ST_FLUSH : ST_IDLE;
            end
          end
          default: begin
            state_nxt = tok_r.last ? ST_FLUSH : ST_IDLE;
          end
        endcase
      end

      ST_FLUSH: begin
        if (stk_empty) begin
          if (emitted_r) begin
            do_clear  = 1'b1;
            state_nxt = ST_IDLE;
          end else if (can_emit) begin
            // Nothing carried the last flag: send a bare end marker
            do_emit   = 1'b1;
            e_last    = 1'b1;
            do_clear  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (top == OP_LP) begin
          err_nxt   = ERR_LPAREN;
          state_nxt = ST_END;
        end else if (can_emit) begin
          do_emit = 1'b1;
          e_kind  = {1'b0, top};
          e_last  = (cnt_r == CW'(1));
          do_pop  = 1'b1;
        end
      end

      ST_END: begin
        if (can_emit) begin
          do_emit     = 1'b1;
          e_last      = 1'b1;
          e_err       = err_r;
          do_clear    = 1'b1;
          err_lat_nxt = !tok_r.last;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_emit) begin
      emitted_nxt = 1'b1;
    end
    if (do_clear) begin
      prev_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      prev_r    <= 1'b0;
      err_lat_r <= 1'b0;
      emitted_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      prev_r    <= prev_nxt;
      err_lat_r <= err_lat_nxt;
      emitted_r <= emitted_nxt;
      if (do_clear) begin
        cnt_r <= '0;
      end else if (do_push) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (do_emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Shift stack: top lives at entry 0
  always_ff @(posedge clk) begin
    if (do_push) begin
      for (int i = STACK_DEPTH - 1; i > 0; i--) begin
        stk_r[i] <= stk_r[i-1];
      end
      stk_r[0] <= push_code;
    end else if (do_pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  // Token and output payload registers
  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    err_r <= err_nxt;
    if (do_emit) begin
      okind_r <= e_kind;
      oid_r   <= e_id;
      olast_r <= e_last;
      oerr_r  <= e_err;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_kind       = okind_r;
  assign out_id         = oid_r;
  assign out_last       = olast_r;
  assign out_error_code = oerr_r;

endmodule

// ----- rtl/bool_infix_to_postfix.sv -----
// Boolean infix-to-postfix converter: front decode, token queue, stack engine.
// Accepted tokens wait in the two-entry queue, so new tokens are taken while the stack
//   engine is still busy; the engine finishes each token before it takes the next.
// Reset (rst_n low, synchronous): stack, queue and error state clear; implicit AND on.
// Depends on bitp_pkg, bitp_front, bitp_queue and bitp_back.
module bool_infix_to_postfix #(
  parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bitp_pkg::KIND_W-1:0]        in_token_kind,
  input  logic signed [bitp_pkg::ID_W-1:0]   in_operand_id,
  input  logic                               in_last_token,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bitp_pkg::KIND_W-1:0]        out_kind,
  output logic signed [bitp_pkg::ID_W-1:0]   out_id,
  output logic                               out_last,
  output logic [bitp_pkg::ERR_W-1:0]         out_error_code
);
  import bitp_pkg::*;

  logic impl_and_r;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  tok_t q_tok;
  tok_t q_head;

  // Implicit AND enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      impl_and_r <= 1'b1;
    end else if (cfg_wr_en) begin
      impl_and_r <= cfg_wr_data;
    end
  end

  bitp_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_token_kind (in_token_kind),
    .in_operand_id (in_operand_id),
    .in_last_token (in_last_token),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_tok         (q_tok)
  );

  bitp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (q_tok),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  bitp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .impl_and_en    (impl_and_r),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_id         (out_id),
    .out_last       (out_last),
    .out_error_code (out_error_code)
  );

  // An error beat is always a final end marker
  a_err_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_NONE) |-> (out_kind == OUT_END && out_last))
    else $error("error code on a beat that is not a final end marker");

  // Only operand beats carry an id
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != OUT_OPERAND) |-> (out_id == '0))
    else $error("nonzero id on a non-operand beat");

  // An accepted token is visible to the stack engine in the next cycle
  a_tok_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> q_valid)
    else $error("accepted token missing from queue");

endmodule

// ----- sim/bool_infix_to_postfix_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bool_infix_to_postfix: directed and random token streams
// are checked beat by beat against a built-in shunting-yard predictor.
// Depends on bitp_pkg and the converter sources in rtl/.
module bool_infix_to_postfix_test;
  import bitp_pkg::*;

  localparam int OPS_DEPTH     = STACK_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int SHOWN_ERRORS  = 10;

  // Token kinds the converter must ignore
  localparam logic [KIND_W-1:0] TK_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] TK_SPARE_B = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              last;
    logic [ERR_W-1:0]  err;
  } postfix_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_wr_data = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [KIND_W-1:0]      in_token_kind = '0;
  logic signed [ID_W-1:0] in_operand_id = '0;
  logic                   in_last_token = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [KIND_W-1:0]      out_kind;
  logic signed [ID_W-1:0] out_id;
  logic                   out_last;
  logic [ERR_W-1:0]       out_error_code;

  // Token streams: one expression under construction, then the driver's backlog
  token_t   expr_tokens[$];
  token_t   pending_tokens[$];
  postfix_t step_items[$];
  postfix_t postfix_expected[$];
  postfix_t want;

  // Predictor state
  op_t ops_stack [OPS_DEPTH];
  int  ops_count = 0;
  bit  term_closed = 1'b0;
  bit  expr_dropped = 1'b0;
  bit  auto_and = 1'b1;

  int tokens_sent = 0;
  int tokens_taken = 0;
  int results_seen = 0;
  int results_drained = 0;
  int mismatches = 0;

  int in_gap = 0;
  int in_steady_left = 0;
  bit in_steady = 1'b0;
  int out_gap = 0;
  int out_steady_left = 0;
  bit out_steady = 1'b0;

  bool_infix_to_postfix u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_token_kind  (in_token_kind),
    .in_operand_id  (in_operand_id),
    .in_last_token  (in_last_token),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_id         (out_id),
    .out_last       (out_last),
    .out_error_code (out_error_code)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void add_postfix(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                      logic last, logic [ERR_W-1:0] err);
    postfix_t p;
    p.kind = kind;
    p.id   = id;
    p.last = last;
    p.err  = err;
    step_items.insert(step_items.size(), p);
  endfunction

  function automatic void clear_expression();
    ops_count    = 0;
    term_closed  = 1'b0;
    expr_dropped = 1'b0;
  endfunction

  function automatic logic [ERR_W-1:0] push_operator(op_t code);
    if (ops_count >= OPS_DEPTH) return ERR_OVERFLOW;
    ops_stack[ops_count] = code;
    ops_count++;
    return ERR_NONE;
  endfunction

  // Pop operators of equal or higher precedence, then push the binary one
  function automatic logic [ERR_W-1:0] reduce_binary(op_t code);
    while (ops_count > 0 && ops_stack[ops_count-1] != OP_LP &&
           ops_stack[ops_count-1] <= code) begin
      add_postfix({1'b0, ops_stack[ops_count-1]}, '0, 1'b0, ERR_NONE);
      ops_count--;
    end
    return push_operator(code);
  endfunction

  function automatic void convert_token(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                        logic last);
    logic [ERR_W-1:0] err;
    postfix_t         tail;
    err = ERR_NONE;
    step_items.delete();
    // Drop everything until the end of a failed expression
    if (expr_dropped) begin
      if (last) clear_expression();
      return;
    end
    if (auto_and && term_closed &&
        (kind == TK_OPERAND || kind == TK_LPAREN || kind == TK_NOT))
      err = reduce_binary(OP_AND);
    if (err == ERR_NONE) begin
      case (kind)
        TK_OPERAND: begin
          add_postfix(OUT_OPERAND, id, 1'b0, ERR_NONE);
          term_closed = 1'b1;
        end
        TK_LPAREN: begin
          err = push_operator(OP_LP);
          term_closed = 1'b0;
        end
        TK_RPAREN: begin
          while (ops_count > 0 && ops_stack[ops_count-1] != OP_LP) begin
            add_postfix({1'b0, ops_stack[ops_count-1]}, '0, 1'b0, ERR_NONE);
            ops_count--;
          end
          if (ops_count == 0) err = ERR_RPAREN;
          else ops_count--;
          term_closed = 1'b1;
        end
        TK_NOT: begin
          err = push_operator(OP_NOT);
          term_closed = 1'b0;
        end
        TK_AND: begin
          err = reduce_binary(OP_AND);
          term_closed = 1'b0;
        end
        TK_OR: begin
          err = reduce_binary(OP_OR);
          term_closed = 1'b0;
        end
        default: ;
      endcase
    end
    // Flush the stack on the last token; a leftover '(' is an error
    if (err == ERR_NONE && last) begin
      while (ops_count > 0 && err == ERR_NONE) begin
        if (ops_stack[ops_count-1] == OP_LP) begin
          err = ERR_LPAREN;
        end else begin
          add_postfix({1'b0, ops_stack[ops_count-1]}, '0, 1'b0, ERR_NONE);
          ops_count--;
        end
      end
    end
    if (err != ERR_NONE) begin
      add_postfix(OUT_END, '0, 1'b1, err);
      clear_expression();
      if (!last) expr_dropped = 1'b1;
    end else if (last) begin
      if (step_items.size() > 0) begin
        tail = step_items.pop_back();
        tail.last = 1'b1;
        step_items.insert(step_items.size(), tail);
      end else begin
        add_postfix(OUT_END, '0, 1'b1, ERR_NONE);
      end
      clear_expression();
    end
    while (step_items.size() > 0)
      postfix_expected.insert(postfix_expected.size(), step_items.pop_front());
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [ID_W-1:0] random_id();
    logic [ID_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 24'h7FFFFF;
      1: v = 24'h800001;
      2: v = '0;
      3: v = '1;
      default: v = ID_W'($urandom_range(24'hFFFFFF, 0));
    endcase
    // Keep ids inside the symmetric signed range
    if (v == 24'h800000) v = 24'h800001;
    return v;
  endfunction

  function automatic void add_token(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
    token_t t;
    t.kind = kind;
    t.id   = id;
    t.last = 1'b0;
    expr_tokens.insert(expr_tokens.size(), t);
  endfunction

  // Mark the final token and hand the expression to the driver
  function automatic void submit_expression();
    token_t t;
    if (expr_tokens.size() == 0) return;
    t = expr_tokens.pop_back();
    t.last = 1'b1;
    expr_tokens.insert(expr_tokens.size(), t);
    while (expr_tokens.size() > 0)
      pending_tokens.insert(pending_tokens.size(), expr_tokens.pop_front());
  endfunction

  function automatic void add_term(int depth);
    int pick;
    pick = (depth >= 3) ? 0 : $urandom_range(0, 9);
    if (pick < 6) begin
      add_token(TK_OPERAND, random_id());
    end else if (pick < 8) begin
      add_token(TK_LPAREN, random_id());
      add_expr(depth + 1);
      add_token(TK_RPAREN, random_id());
    end else begin
      add_token(TK_NOT, random_id());
      add_term(depth + 1);
    end
  endfunction

  // Well-formed expression; adjacent terms rely on the implicit AND
  function automatic void add_expr(int depth);
    int terms;
    int i;
    terms = $urandom_range(1, 4);
    add_term(depth);
    for (i = 1; i < terms; i++) begin
      case ($urandom_range(0, 4))
        0, 1: add_token(TK_AND, random_id());
        2, 3: add_token(TK_OR, random_id());
        default: ;
      endcase
      add_term(depth);
    end
  endfunction

  // Deep nesting that drives the stack to its limit and past it
  function automatic void add_deep_nest();
    int levels;
    int opens;
    levels = $urandom_range(14, 17);
    opens = 0;
    repeat (levels) begin
      case ($urandom_range(0, 4))
        0, 1, 2: begin
          add_token(TK_LPAREN, random_id());
          opens++;
        end
        3: add_token(TK_NOT, random_id());
        default: add_token(TK_OPERAND, random_id());
      endcase
    end
    add_token(TK_OPERAND, random_id());
    repeat (opens) add_token(TK_RPAREN, random_id());
  endfunction

  function automatic void add_noise();
    int count;
    count = $urandom_range(1, 6);
    repeat (count) add_token(KIND_W'($urandom_range(0, 7)), random_id());
  endfunction

  // Insert a stray paren or an ignored kind at a random place
  function automatic void break_expression();
    token_t t;
    int     pos;
    pos = $urandom_range(0, expr_tokens.size());
    t.id = random_id();
    t.last = 1'b0;
    case ($urandom_range(0, 3))
      0: t.kind = TK_RPAREN;
      1: t.kind = TK_LPAREN;
      2: t.kind = TK_SPARE_A;
      default: t.kind = TK_SPARE_B;
    endcase
    expr_tokens.insert(pos, t);
  endfunction

  function automatic void queue_random_phase(int budget);
    int queued;
    queued = 0;
    while (queued < budget) begin
      expr_tokens.delete();
      case ($urandom_range(0, 11))
        0: add_deep_nest();
        1: add_noise();
        default: add_expr(0);
      endcase
      if ($urandom_range(0, 5) == 0) break_expression();
      queued += expr_tokens.size();
      submit_expression();
    end
  endfunction

  // Wait per beat, with stretches of back-to-back traffic
  function automatic int draw_wait(inout int steady_left, inout bit steady);
    if (steady_left == 0) begin
      steady = ($urandom_range(0, 3) == 0);
      steady_left = $urandom_range(4, 20);
    end
    steady_left--;
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic write_implicit_and(bit enable);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= enable;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    auto_and = enable;
  endtask

  // Hold until every token is taken and every postfix beat has arrived
  task automatic wait_drained();
    while (pending_tokens.size() != 0 || tokens_taken != tokens_sent ||
           postfix_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------- driver and sink

  // Present the next token at the falling edge; hold it until accepted
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || tokens_taken == tokens_sent) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (pending_tokens.size() > 0) begin
          in_valid      <= 1'b1;
          in_token_kind <= pending_tokens[0].kind;
          in_operand_id <= pending_tokens[0].id;
          in_last_token <= pending_tokens[0].last;
          void'(pending_tokens.pop_front());
          tokens_sent++;
          in_gap = draw_wait(in_steady_left, in_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side for a random time after each beat
  always @(negedge clk) begin
    if (rst_n) begin
      if (results_seen != results_drained) begin
        results_drained = results_seen;
        out_gap = draw_wait(out_steady_left, out_steady);
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst_n) begin
      // Check each postfix beat against the oldest expectation
      if (out_valid && out_ready) begin
        results_seen++;
        if (postfix_expected.size() == 0) begin
          note_mismatch($sformatf(
            "postfix beat %0d: none expected, got kind=%0d id=%0d last=%0d err=%0d",
            results_seen, out_kind, out_id, out_last, out_error_code));
        end else begin
          want = postfix_expected.pop_front();
          if (out_kind !== want.kind || out_id !== want.id ||
              out_last !== want.last || out_error_code !== want.err)
            note_mismatch({
              $sformatf("postfix beat %0d: expected kind=%0d id=%0d last=%0d err=%0d,",
                        results_seen, want.kind, $signed(want.id), want.last, want.err),
              $sformatf(" got kind=%0d id=%0d last=%0d err=%0d",
                        out_kind, out_id, out_last, out_error_code)});
        end
      end
      // Predict the beats caused by each accepted token
      if (in_valid && in_ready) begin
        tokens_taken++;
        convert_token(in_token_kind, in_operand_id, in_last_token);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_implicit_and(1'b1);
    // Single operand at the positive extreme
    add_token(TK_OPERAND, 24'h7FFFFF);
    submit_expression();
    // Every operator with the negative, zero and all-ones ids
    add_token(TK_OPERAND, 24'h800001);
    add_token(TK_AND, '0);
    add_token(TK_OPERAND, '0);
    add_token(TK_OR, '1);
    add_token(TK_NOT, '0);
    add_token(TK_OPERAND, '1);
    submit_expression();
    // Implicit AND between ')' and an operand
    add_token(TK_LPAREN, '1);
    add_token(TK_OPERAND, 24'h000123);
    add_token(TK_RPAREN, '1);
    add_token(TK_OPERAND, 24'hFFFF00);
    submit_expression();
    // Unmatched ')', then the rest of the expression is dropped
    add_token(TK_RPAREN, '0);
    add_token(TK_OPERAND, 24'h000055);
    submit_expression();
    // Unmatched '(' left at the end
    add_token(TK_LPAREN, '0);
    add_token(TK_OPERAND, 24'h0000AA);
    submit_expression();
    // Nothing left to carry the last flag
    add_token(TK_OPERAND, 24'h400000);
    add_token(TK_SPARE_B, '1);
    submit_expression();
    // Ignored last token still flushes the stack
    add_token(TK_OPERAND, 24'h000001);
    add_token(TK_OR, '0);
    add_token(TK_OPERAND, 24'h000002);
    add_token(TK_SPARE_A, '1);
    submit_expression();
    wait_drained();

    write_implicit_and(1'b0);
    // Adjacent terms without the implicit AND
    add_token(TK_OPERAND, 24'h000003);
    add_token(TK_NOT, '0);
    add_token(TK_OPERAND, 24'h000004);
    submit_expression();
    wait_drained();

    write_implicit_and(1'b1);
    queue_random_phase(28);
    wait_drained();

    write_implicit_and(1'b0);
    queue_random_phase(24);
    wait_drained();

    write_implicit_and(1'b1);
    queue_random_phase(24);
    wait_drained();

    if (mismatches == 0) begin
      $display("bool_infix_to_postfix test passed");
    end else begin
      $display("bool_infix_to_postfix test failed");
    end
    $finish;
  end

  // Give up if the run stalls
  initial begin
    #5_000_000;
    $display("bool_infix_to_postfix test failed");
    $finish;
  end

endmodule
